/* design/xfbe_pkg.sv */
// Shared types, constants and bit-count functions for the XOR float byte encoder.
package xfbe_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Stream constants
    localparam logic [7:0] BYTE_SAME  = 8'h00;
    localparam logic [7:0] BYTE_DELTA = 8'h01;
    localparam logic [7:0] VARINT_MORE = 8'h80;
    localparam logic [6:0] VARINT_MASK = 7'h7F;
    localparam logic [2:0] RAW_LAST_IDX = 3'd7;

    // Class of one queued sample
    typedef enum logic [1:0] {
        K_RAW   = 2'd0,
        K_SAME  = 2'd1,
        K_DELTA = 2'd2
    } t_kind;

    // One queued sample: raw value or XOR word, plus its zero counts
    typedef struct packed {
        t_kind       kind;
        logic [63:0] data;
        logic [5:0]  lead;
        logic [5:0]  trail;
    } t_entry;

    // Count trailing zeros of a non-zero word by halving
    function automatic logic [5:0] trail_zeros(input logic [63:0] x);
        logic [63:0] y;
        logic [5:0]  n;
        logic [63:0] m;
        y = x;
        n = '0;
        for (int i = 5; i >= 0; i--) begin
            m = (64'd1 << (1 << i)) - 64'd1;
            if ((y & m) == 64'd0) begin
                n[i] = 1'b1;
                y = y >> (1 << i);
            end
        end
        return n;
    endfunction

    // Count leading zeros of a non-zero word
    function automatic logic [5:0] lead_zeros(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[i] = x[63 - i];
        end
        return trail_zeros(r);
    endfunction

endpackage

/* design/xfbe_front.sv */
// Front end: holds the reference value and classifies each accepted sample.
module xfbe_front
    import xfbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [63:0] i_value_bits,
    input  logic        i_block_start,
    output t_entry      o_entry
);

    logic [63:0] r_prev;
    logic        r_open;
    logic [63:0] w_xor;

    // Classify the incoming word against the stored value
    always_comb begin
        w_xor         = r_prev ^ i_value_bits;
        o_entry.lead  = lead_zeros(w_xor);
        o_entry.trail = trail_zeros(w_xor);
        priority if (i_block_start || !r_open) begin
            o_entry.kind = K_RAW;
            o_entry.data = i_value_bits;
        end else if (w_xor == 64'd0) begin
            o_entry.kind = K_SAME;
            o_entry.data = w_xor;
        end else begin
            o_entry.kind = K_DELTA;
            o_entry.data = w_xor;
        end
    end

    // Track block state; an unchanged word equals the stored one, so always load it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_prev <= i_value_bits;
            r_open <= 1'b1;
        end
    end

endmodule

/* design/xfbe_queue.sv */
// Short queue of classified samples between front and back.
module xfbe_queue
    import xfbe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_head];

    // Write the new word at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + PW'(1);
            end
            if (i_pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/xfbe_back.sv */
// Back end: walks each queued sample out as bytes into the output register.
module xfbe_back
    import xfbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_entry     i_entry,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RAW  = 6'b000010,
        ST_SAME = 6'b000100,
        ST_CTRL = 6'b001000,
        ST_LEAD = 6'b010000,
        ST_VAR  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_val, n_val;
    logic [5:0]  r_lead, n_lead;
    logic [5:0]  r_trail, n_trail;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic       w_adv;
    logic       w_emit;
    logic [7:0] w_byte;
    logic       w_last;
    logic       w_load;

    assign w_adv       = !r_out_valid || i_pop;
    assign w_emit      = (r_state != ST_IDLE);
    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    // Pick the byte for the current step
    always_comb begin
        unique case (r_state)
            ST_RAW: begin
                w_byte = r_val[7:0];
                w_last = (r_cnt == RAW_LAST_IDX);
            end
            ST_SAME: begin
                w_byte = BYTE_SAME;
                w_last = 1'b1;
            end
            ST_CTRL: begin
                w_byte = BYTE_DELTA;
                w_last = 1'b0;
            end
            ST_LEAD: begin
                w_byte = {2'b00, r_lead};
                w_last = 1'b0;
            end
            ST_VAR: begin
                w_last = (r_val[63:7] == 57'd0);
                w_byte = {1'b0, r_val[6:0] & VARINT_MASK} | (w_last ? 8'h00 : VARINT_MORE);
            end
            default: begin
                w_byte = BYTE_SAME;
                w_last = 1'b0;
            end
        endcase
    end

    // Load the next word when idle or when the last byte leaves
    assign w_load  = !i_q_empty && ((r_state == ST_IDLE) || (w_adv && w_last));
    assign o_q_pop = w_load;

    // Step the sequencer
    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_lead  = r_lead;
        n_trail = r_trail;
        n_cnt   = r_cnt;
        if (w_adv && w_emit) begin
            unique case (r_state)
                ST_RAW: begin
                    n_val = r_val >> 8;
                    n_cnt = r_cnt + 3'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_SAME: n_state = ST_IDLE;
                ST_CTRL: begin
                    n_val   = r_val >> r_trail;
                    n_state = ST_LEAD;
                end
                ST_LEAD: n_state = ST_VAR;
                ST_VAR: begin
                    n_val = r_val >> 7;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
        if (w_load) begin
            n_val   = i_entry.data;
            n_lead  = i_entry.lead;
            n_trail = i_entry.trail;
            n_cnt   = '0;
            unique case (i_entry.kind)
                K_RAW:   n_state = ST_RAW;
                K_SAME:  n_state = ST_SAME;
                K_DELTA: n_state = ST_CTRL;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_val   <= n_val;
        r_lead  <= n_lead;
        r_trail <= n_trail;
        r_cnt   <= n_cnt;
    end

    // Drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

endmodule

/* design/xor_float_byte_encoder.sv */
// Top level of the XOR float byte encoder.
//
// Usage: write one 64-bit double bit pattern per word on the input queue
// (push/full, with i_block_start marking the first sample of a block) and
// read the compressed stream one byte per word from the output queue
// (empty/pop, o_out_byte with o_last_byte on the final byte of a sample).
// A block-start sample gives 8 raw bytes, least significant first; an
// unchanged sample gives one byte; a changed sample gives a control byte,
// a leading-zero byte and a 1 to 10 byte varint of the shifted XOR.
// A sample's first byte reaches the output through the queue, the
// sequencer state register in the back end and the output register.
// Throughput: the back end sends one byte per cycle without gaps between
// samples while the receiver pops and the queue holds samples; the
// input side takes a word per cycle until the front-to-back queue
// (QUEUE_DEPTH words) fills.
// Reset clears the stored value and marks no block open, so the first
// sample after reset is sent raw. If the receiver stalls, the output byte
// holds, the back end waits, and full rises once the queue fills.
module xor_float_byte_encoder
    import xfbe_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_value_bits,
    input  logic        i_block_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    t_entry w_front_entry;
    t_entry w_head_entry;
    logic   w_accept;
    logic   w_q_empty;
    logic   w_q_pop;

    assign w_accept = push && !full;

    // Classify incoming samples
    xfbe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_value_bits  (i_value_bits),
        .i_block_start (i_block_start),
        .o_entry       (w_front_entry)
    );

    // Buffer classified samples
    xfbe_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_front_entry),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_entry (w_head_entry)
    );

    // Serialize into bytes
    xfbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_entry     (w_head_entry),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
